### hdl/bounded_deque_with_search_defines.svh
// Assertion macros for the bounded deque checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH

// same-cycle implication
`define BDQS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bdqs check failed");

// next-cycle implication
`define BDQS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bdqs check failed");

`endif

### hdl/bdqs_pkg.sv
// Shared types and constants of the bounded deque.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdqs_pkg;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CONTAINS   = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_CLEAR      = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

`default_nettype wire

### hdl/bdqs_if.sv
// Request and response channel interfaces of the bounded deque.
// Depends on bdqs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bdqs_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [bdqs_pkg::OPCODE_W-1:0]        opcode;
  logic signed [bdqs_pkg::VALUE_W-1:0]  operand_value;

  modport source (output valid, output opcode, output operand_value, input ready);
  modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

interface bdqs_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [bdqs_pkg::STATUS_W-1:0]        status;
  logic                                 found;
  logic signed [bdqs_pkg::VALUE_W-1:0]  front_value;
  logic signed [bdqs_pkg::VALUE_W-1:0]  back_value;
  logic [bdqs_pkg::TOTAL_W-1:0]         entry_total;
  logic                                 is_empty;

  modport source (output valid, output status, output found, output front_value,
                  output back_value, output entry_total, output is_empty, input ready);
  modport sink   (input valid, input status, input found, input front_value,
                  input back_value, input entry_total, input is_empty, output ready);
endinterface

`default_nettype wire

### hdl/bounded_deque_with_search.sv
// Bounded double-ended queue with search, held in one ring memory.
// Depends on bdqs_pkg and the interfaces in bdqs_if.
//
// Usage:
//   req carries one request (opcode, operand_value); it is taken when
//   valid and ready are both high. rsp returns exactly one result per
//   request, in order, with the queue state after the operation.
//   Requests are worked one at a time. Each passes through the fetch
//   and result states before the result register is loaded; contains
//   and remove on a non-empty queue first walk the stored entries
//   through read port A, one per cycle, and a removal is followed by
//   a shift of the later entries.
//   The result sits in an output register; the next request is taken
//   while it waits. If the receiver stalls, the following result is
//   held back until the register frees, and req.ready stays low.
//   Reset (rst_ni low, asynchronous) empties the queue and clears the
//   head index; memory contents are not cleared and need no sweep.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_search #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  bdqs_req_if.sink     req,
  bdqs_rsp_if.source   rsp
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SUMW = CW + 1;
  localparam int PW   = bdqs_pkg::VALUE_W;
  localparam int TW   = bdqs_pkg::TOTAL_W;
  // stored width: operands are 32 bits on the port
  localparam int SW   = (VALUE_WIDTH < PW) ? VALUE_WIDTH : PW;

  localparam logic [CW-1:0] DepthC   = CW'(DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_FETCH  = 5'b01000,
    S_RESP   = 5'b10000
  } state_e;

  // ring position -> memory slot; sum stays below twice the depth for positions up to the depth
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] pos);
    logic [SUMW-1:0] sum;
    sum = SUMW'(head) + SUMW'(pos);
    if (sum >= SUMW'(DEPTH)) begin
      sum = sum - SUMW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  state_e                 state_q, state_d;
  logic [AW-1:0]          head_q, head_d;
  logic [CW-1:0]          count_q, count_d;
  bdqs_pkg::op_e          op_q, op_d;
  logic [SW-1:0]          value_q, value_d;
  logic [CW-1:0]          idx_q, idx_d;        // next position to read
  logic                   pend_q, pend_d;      // read data in flight
  logic [CW-1:0]          pend_pos_q, pend_pos_d;
  bdqs_pkg::status_e      status_q, status_d;
  logic                   found_q, found_d;

  logic                   out_valid_q, out_valid_d;
  logic [1:0]             out_status_q, out_status_d;
  logic                   out_found_q, out_found_d;
  logic [PW-1:0]          out_front_q, out_front_d;
  logic [PW-1:0]          out_back_q, out_back_d;
  logic [TW-1:0]          out_total_q, out_total_d;
  logic                   out_empty_q, out_empty_d;

  // ring memory, one write and two registered reads per cycle
  logic [SW-1:0]          mem_q [DEPTH];
  logic [SW-1:0]          rd_a_q, rd_b_q;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [SW-1:0]          wdata;
  logic [AW-1:0]          ra_addr, rb_addr;

  logic                   in_ready;
  logic                   req_fire;
  logic [SW-1:0]          in_val;
  logic                   issue;
  logic                   hit;

  assign in_ready = (state_q == S_IDLE);
  assign req_fire = req.valid && in_ready;
  assign in_val   = req.operand_value[SW-1:0];
  assign req.ready = in_ready;

  // port A walks positions during search/shift, holds the front in fetch
  // and while the result waits for the output register
  assign ra_addr = slot_of(head_q, (state_q == S_FETCH || state_q == S_RESP) ? '0 : idx_q);
  assign rb_addr = slot_of(head_q, count_q - CW'(1));

  assign issue = (idx_q < count_q);
  assign hit   = pend_q && (rd_a_q == value_q);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    op_d         = op_q;
    value_d      = value_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_pos_d   = pend_pos_q;
    status_d     = status_q;
    found_d      = found_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_front_d  = out_front_q;
    out_back_d   = out_back_q;
    out_total_d  = out_total_q;
    out_empty_d  = out_empty_q;
    we           = 1'b0;
    waddr        = slot_of(head_q, count_q);
    wdata        = in_val;

    if (out_valid_q && rsp.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          op_d     = bdqs_pkg::op_e'(req.opcode);
          value_d  = in_val;
          status_d = bdqs_pkg::ST_OK;
          found_d  = 1'b0;
          idx_d    = '0;
          pend_d   = 1'b0;
          state_d  = S_FETCH;
          case (bdqs_pkg::op_e'(req.opcode))
            bdqs_pkg::OP_PUSH_FRONT: begin
              if (count_q == DepthC) begin
                status_d = bdqs_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = (head_q == '0) ? LastSlot : head_q - AW'(1);
                head_d  = waddr;
                count_d = count_q + CW'(1);
              end
            end
            bdqs_pkg::OP_PUSH_BACK: begin
              if (count_q == DepthC) begin
                status_d = bdqs_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            bdqs_pkg::OP_POP_FRONT: begin
              if (count_q == '0) begin
                status_d = bdqs_pkg::ST_EMPTY;
              end else begin
                head_d  = (head_q == LastSlot) ? '0 : head_q + AW'(1);
                count_d = count_q - CW'(1);
              end
            end
            bdqs_pkg::OP_POP_BACK: begin
              if (count_q == '0) begin
                status_d = bdqs_pkg::ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            bdqs_pkg::OP_CONTAINS, bdqs_pkg::OP_REMOVE: begin
              if (count_q != '0) begin
                state_d = S_SEARCH;
              end
            end
            bdqs_pkg::OP_CLEAR: begin
              count_d = '0;
              head_d  = '0;
            end
            default: ;
          endcase
        end
      end

      S_SEARCH: begin
        // one read issued, one compare of the previous read per cycle
        if (issue) begin
          idx_d      = idx_q + CW'(1);
          pend_d     = 1'b1;
          pend_pos_d = idx_q;
        end else begin
          pend_d = 1'b0;
        end
        if (hit) begin
          found_d = 1'b1;
          if (op_q == bdqs_pkg::OP_REMOVE) begin
            state_d = S_SHIFT;
            idx_d   = pend_pos_q + CW'(1);
            pend_d  = 1'b0;
          end else begin
            state_d = S_FETCH;
          end
        end else if (!pend_q && !issue) begin
          state_d = S_FETCH;
        end
      end

      S_SHIFT: begin
        // read position j+2 while writing the data of the last read, position j+1, to j
        if (issue) begin
          idx_d      = idx_q + CW'(1);
          pend_d     = 1'b1;
          pend_pos_d = idx_q;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          we    = 1'b1;
          waddr = slot_of(head_q, pend_pos_q - CW'(1));
          wdata = rd_a_q;
        end else if (!issue) begin
          count_d = count_q - CW'(1);
          state_d = S_FETCH;
        end
      end

      S_FETCH: begin
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || rsp.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_found_d  = found_q;
          out_front_d  = (count_q == '0) ? '0 : PW'(rd_a_q);
          out_back_d   = (count_q == '0) ? '0 : PW'(rd_b_q);
          out_total_d  = TW'(count_q);
          out_empty_d  = (count_q == '0);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    value_q      <= value_d;
    pend_pos_q   <= pend_pos_d;
    status_q     <= status_d;
    found_q      <= found_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_front_q  <= out_front_d;
    out_back_q   <= out_back_d;
    out_total_q  <= out_total_d;
    out_empty_q  <= out_empty_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_a_q <= mem_q[ra_addr];
    rd_b_q <= mem_q[rb_addr];
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.status      = out_status_q;
  assign rsp.found       = out_found_q;
  assign rsp.front_value = $signed(out_front_q);
  assign rsp.back_value  = $signed(out_back_q);
  assign rsp.entry_total = out_total_q;
  assign rsp.is_empty    = out_empty_q;

endmodule

`default_nettype wire

### hdl/bdqs_checker.sv
// Port-level checker for the bounded deque, bound to the top level.
// Depends on bdqs_pkg and bounded_deque_with_search_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_deque_with_search_defines.svh"

module bdqs_checker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               req_valid_i,
  input  wire logic                               req_ready_i,
  input  wire logic                               rsp_valid_i,
  input  wire logic                               rsp_ready_i,
  input  wire logic [bdqs_pkg::STATUS_W-1:0]      rsp_status_i,
  input  wire logic                               rsp_found_i,
  input  wire logic [bdqs_pkg::VALUE_W-1:0]       rsp_front_i,
  input  wire logic [bdqs_pkg::VALUE_W-1:0]       rsp_back_i,
  input  wire logic [bdqs_pkg::TOTAL_W-1:0]       rsp_total_i
);

  logic       req_fire;
  logic       rsp_fire;
  logic [1:0] open_q, open_d;   // requests without a delivered result

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  always_comb begin
    open_d = open_q;
    if (req_fire && !rsp_fire) begin
      open_d = open_q + 2'd1;
    end else if (rsp_fire && !req_fire) begin
      open_d = open_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  `BDQS_ASSERT_IMP(a_no_stray_rsp, rsp_valid_i, open_q != 2'd0)
  `BDQS_ASSERT_IMP(a_two_open_max, req_fire, open_q < 2'd2)
  `BDQS_ASSERT_NXT(a_one_at_a_time, req_fire, !req_ready_i)
  `BDQS_ASSERT_NXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_found_i) && $stable(rsp_front_i) && $stable(rsp_back_i) && $stable(rsp_total_i))

endmodule

bind bounded_deque_with_search bdqs_checker u_bdqs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req.valid),
  .req_ready_i  (req.ready),
  .rsp_valid_i  (rsp.valid),
  .rsp_ready_i  (rsp.ready),
  .rsp_status_i (rsp.status),
  .rsp_found_i  (rsp.found),
  .rsp_front_i  (rsp.front_value),
  .rsp_back_i   (rsp.back_value),
  .rsp_total_i  (rsp.entry_total)
);

`default_nettype wire

### tb/bdqs_deque_monitor.sv
// Checker for the bounded deque: keeps a shadow copy of the ring and compares results.
// Depends on bdqs_pkg and the bdqs_req_if / bdqs_rsp_if interfaces.
`timescale 1ns / 1ps

module bdqs_deque_monitor #(
  parameter int DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  bdqs_req_if  req,
  bdqs_rsp_if  rsp,
  output int   mismatches_o,
  output int   pending_o,
  output int   results_checked_o,
  output int   full_rejects_o,
  output int   empty_rejects_o,
  output int   search_hits_o
);
  import bdqs_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic                      found;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] back_value;
    logic [TOTAL_W-1:0]        entry_total;
    logic                      is_empty;
  } deque_snapshot_t;

  // shadow ring, head and fill level
  logic [VALUE_W-1:0] ring [DEPTH];
  int                 head;
  int                 fill;

  deque_snapshot_t awaited_snapshots[$];

  function automatic bit locate_value(input logic [VALUE_W-1:0] value, output int pos);
    pos = 0;
    for (int i = 0; i < fill; i++) begin
      if (ring[(head + i) % DEPTH] == value) begin
        pos = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic step_shadow_deque(input logic [OPCODE_W-1:0] op,
                                   input logic [VALUE_W-1:0] value,
                                   output deque_snapshot_t snap);
    int pos;
    snap = '0;
    snap.status = ST_OK;
    case (op)
      OP_PUSH_FRONT: begin
        if (fill >= DEPTH) begin
          snap.status = ST_FULL;
        end else begin
          head = (head + DEPTH - 1) % DEPTH;
          ring[head] = value;
          fill++;
        end
      end
      OP_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          snap.status = ST_FULL;
        end else begin
          ring[(head + fill) % DEPTH] = value;
          fill++;
        end
      end
      OP_POP_FRONT: begin
        if (fill == 0) begin
          snap.status = ST_EMPTY;
        end else begin
          head = (head + 1) % DEPTH;
          fill--;
        end
      end
      OP_POP_BACK: begin
        if (fill == 0) snap.status = ST_EMPTY;
        else fill--;
      end
      OP_CONTAINS: snap.found = locate_value(value, pos);
      OP_REMOVE: begin
        if (locate_value(value, pos)) begin
          snap.found = 1'b1;
          // later entries close the gap toward the front
          for (int j = pos; j + 1 < fill; j++)
            ring[(head + j) % DEPTH] = ring[(head + j + 1) % DEPTH];
          fill--;
        end
      end
      OP_CLEAR: begin
        fill = 0;
        head = 0;
      end
      default: ;  // unused opcode leaves the queue alone
    endcase
    snap.entry_total = TOTAL_W'(fill);
    snap.is_empty    = (fill == 0);
    if (fill != 0) begin
      snap.front_value = ring[head];
      snap.back_value  = ring[(head + fill - 1) % DEPTH];
    end
  endtask

  task automatic check_result();
    deque_snapshot_t want;
    deque_snapshot_t got;
    got.status      = rsp.status;
    got.found       = rsp.found;
    got.front_value = rsp.front_value;
    got.back_value  = rsp.back_value;
    got.entry_total = rsp.entry_total;
    got.is_empty    = rsp.is_empty;
    if (awaited_snapshots.size() == 0) begin
      mismatches_o++;
      if (mismatches_o <= REPORT_LIMIT)
        $display("%0t: result with no request outstanding", $realtime);
      return;
    end
    want = awaited_snapshots.pop_front();
    results_checked_o++;
    if (want.status == ST_FULL) full_rejects_o++;
    if (want.status == ST_EMPTY) empty_rejects_o++;
    if (want.found) search_hits_o++;
    if (got.status !== want.status || got.found !== want.found ||
        got.front_value !== want.front_value || got.back_value !== want.back_value ||
        got.entry_total !== want.entry_total || got.is_empty !== want.is_empty) begin
      mismatches_o++;
      if (mismatches_o <= REPORT_LIMIT) begin
        $display("%0t: result %0d exp st=%0d fnd=%0b front=%0d back=%0d total=%0d empty=%0b",
                 $realtime, results_checked_o, want.status, want.found,
                 want.front_value, want.back_value, want.entry_total, want.is_empty);
        $display("%0t: result %0d got st=%0d fnd=%0b front=%0d back=%0d total=%0d empty=%0b",
                 $realtime, results_checked_o, got.status, got.found,
                 got.front_value, got.back_value, got.entry_total, got.is_empty);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    deque_snapshot_t snap;
    if (!rst_ni) begin
      head = 0;
      fill = 0;
      awaited_snapshots.delete();
      mismatches_o      = 0;
      pending_o         = 0;
      results_checked_o = 0;
      full_rejects_o    = 0;
      empty_rejects_o   = 0;
      search_hits_o     = 0;
    end else begin
      // a result never belongs to a request taken at the same edge
      if (rsp.valid && rsp.ready) check_result();
      if (req.valid && req.ready) begin
        step_shadow_deque(req.opcode, req.operand_value, snap);
        awaited_snapshots.push_back(snap);
      end
      pending_o = awaited_snapshots.size();
    end
  end

endmodule

### tb/tb_bounded_deque_with_search.sv
// Top of the bounded deque testbench: clock, reset, request and response drivers, verdict.
// Depends on bdqs_pkg, bdqs_if, bounded_deque_with_search and bdqs_deque_monitor.
`timescale 1ns / 1ps

module tb_bounded_deque_with_search;
  import bdqs_pkg::*;

  localparam int DEQUE_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 365;   // per idle mix
  localparam int BIAS_SPAN    = 30;    // requests between fill and drain leanings
  localparam int BURST_ITEMS  = 40;    // pushes offered while the receiver holds off
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 40;
  localparam int QUIET_LIMIT  = 3000;  // cycles with no handshake before giving up
  localparam int POOL_SIZE    = 6;

  // opcode seven has no member in op_e; the block treats it as a no-op
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bdqs_req_if req_ch ();
  bdqs_rsp_if rsp_ch ();

  bounded_deque_with_search #(
    .DEPTH       (DEQUE_DEPTH),
    .VALUE_WIDTH (VALUE_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  int mismatches;
  int pending;
  int results_checked;
  int full_rejects;
  int empty_rejects;
  int search_hits;

  bdqs_deque_monitor #(
    .DEPTH (DEQUE_DEPTH)
  ) u_monitor (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req               (req_ch),
    .rsp               (rsp_ch),
    .mismatches_o      (mismatches),
    .pending_o         (pending),
    .results_checked_o (results_checked),
    .full_rejects_o    (full_rejects),
    .empty_rejects_o   (empty_rejects),
    .search_hits_o     (search_hits)
  );

  // idle percentages per cycle, switched between phases
  int tx_idle_pct;
  int rx_idle_pct;

  // long receiver hold-offs: stimulus asks, the receiver serves
  int hold_requests = 0;
  int holds_served  = 0;

  int requests_sent = 0;

  // small value pool so that contains and remove often hit
  logic [VALUE_W-1:0] operand_pool [POOL_SIZE];

  //--------------------------------------------------------------------------
  // Request driver. Entered and left at a falling edge; one valid
  // assignment per step, so back-to-back requests keep valid high.
  //--------------------------------------------------------------------------
  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] value);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.operand_value <= value;
    do @(posedge clk_i); while (!req_ch.ready);
    requests_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [VALUE_W-1:0] pick_operand();
    if ($urandom_range(0, 9) < 6) return operand_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Filling leans on pushes so the ring reaches full; draining leans on
  // pops so it empties and wraps the head the other way.
  function automatic logic [OPCODE_W-1:0] pick_opcode(input bit filling);
    int roll;
    int push_w;
    int pop_w;
    push_w = filling ? 25 : 12;
    pop_w  = filling ? 8 : 22;
    roll   = $urandom_range(0, 99);
    if (roll < push_w) return OP_PUSH_FRONT;
    roll -= push_w;
    if (roll < push_w) return OP_PUSH_BACK;
    roll -= push_w;
    if (roll < pop_w) return OP_POP_FRONT;
    roll -= pop_w;
    if (roll < pop_w) return OP_POP_BACK;
    roll -= pop_w;
    if (roll < 13) return OP_CONTAINS;
    roll -= 13;
    if (roll < 15) return OP_REMOVE;
    roll -= 15;
    if (roll < 1) return OP_CLEAR;
    return OP_UNUSED;
  endfunction

  task automatic run_random_phase(input int items);
    bit filling;
    filling = 1'b1;
    for (int k = 0; k < POOL_SIZE; k++) operand_pool[k] = $urandom;
    for (int n = 0; n < items; n++) begin
      if (n % BIAS_SPAN == BIAS_SPAN - 1) filling = !filling;
      send_request(pick_opcode(filling), pick_operand());
    end
  endtask

  //--------------------------------------------------------------------------
  // Response receiver: random stalls, plus a long hold-off when asked.
  // Counted here so the sender keeps offering requests meanwhile.
  //--------------------------------------------------------------------------
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_served < hold_requests) begin
        holds_served++;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  //--------------------------------------------------------------------------
  // Watchdog: cycles with no request and no result taken.
  //--------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Stimulus and verdict
  //--------------------------------------------------------------------------
  initial begin
    rst_ni               = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.opcode        = OP_PUSH_FRONT;
    req_ch.operand_value = '0;
    tx_idle_pct          = 27;
    rx_idle_pct          = 58;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: pops, searches and the unused opcode on an empty queue first
    // (pops rejected, searches miss), then extremes, duplicates and removal at each end.
    send_request(OP_POP_FRONT, 32'd0);
    send_request(OP_POP_BACK, 32'd0);
    send_request(OP_CONTAINS, 32'd5);
    send_request(OP_REMOVE, 32'd5);
    send_request(OP_UNUSED, 32'hFFFF_FFFF);
    send_request(OP_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(OP_PUSH_FRONT, 32'h8000_0000);
    send_request(OP_PUSH_BACK, 32'h0000_0000);
    send_request(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(OP_PUSH_BACK, 32'h7FFF_FFFF);   // duplicate at the back
    send_request(OP_CONTAINS, 32'h0000_0000);
    send_request(OP_CONTAINS, 32'd12345);
    send_request(OP_REMOVE, 32'h7FFF_FFFF);      // first copy only, middle shifts
    send_request(OP_REMOVE, 32'd12345);          // no match, queue unchanged
    send_request(OP_REMOVE, 32'hFFFF_FFFF);      // front entry
    send_request(OP_REMOVE, 32'h7FFF_FFFF);      // back entry
    send_request(OP_UNUSED, 32'h1234_5678);
    send_request(OP_POP_BACK, 32'd0);
    send_request(OP_POP_FRONT, 32'd0);
    send_request(OP_PUSH_FRONT, 32'hA5A5_A5A5);
    send_request(OP_CLEAR, 32'd0);
    send_request(OP_CONTAINS, 32'hA5A5_A5A5);    // stale memory must not match
    send_request(OP_PUSH_FRONT, 32'h5A5A_5A5A);  // head wraps below zero
    send_request(OP_POP_BACK, 32'd0);

    run_random_phase(RANDOM_ITEMS);

    tx_idle_pct = 58;
    rx_idle_pct = 27;
    run_random_phase(RANDOM_ITEMS);

    // No idling; the receiver is held off first so the block stalls its input,
    // then a burst of pushes fills the ring and further pushes get rejected as full.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_request(OP_CLEAR, 32'd0);
    hold_requests++;
    for (int n = 0; n < BURST_ITEMS; n++)
      send_request(($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom);
    run_random_phase(RANDOM_ITEMS);

    req_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests over three idle mixes and a receiver hold-off.",
             requests_sent);
    $display("Checked %0d results: %0d full, %0d empty rejections, %0d search hits.",
             results_checked, full_rejects, empty_rejects, search_hits);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
